// ===== hw/rtl/siphash_pkg.sv =====
// ----------------------------------------------------------------------------
// siphash_pkg
// Types, constants and round functions for the SipHash-2-4 keyed hash.
// ----------------------------------------------------------------------------
package siphash_pkg;

  localparam int WORD_W = 64;
  localparam int LEN_W  = 8;
  localparam int CNT_W  = 4;

  // Bytes in a full message word
  localparam logic [CNT_W-1:0] FULL_BYTES = 4'd8;

  // Initialization constants ("somepseudorandomlygeneratedbytes")
  localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;

  // Finalization constant folded into v2
  localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  // SipRound rotation amounts
  localparam int ROT_13 = 13;
  localparam int ROT_16 = 16;
  localparam int ROT_17 = 17;
  localparam int ROT_21 = 21;
  localparam int ROT_32 = 32;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  // Four-word hash state
  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } sip_state_t;

  function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] x, int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic sip_state_t key_load(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1);
    sip_state_t s;
    s.v0 = SIP_C0 ^ k0;
    s.v1 = SIP_C1 ^ k1;
    s.v2 = SIP_C2 ^ k0;
    s.v3 = SIP_C3 ^ k1;
    return s;
  endfunction

  function automatic sip_state_t sip_round(sip_state_t s);
    sip_state_t r;
    r    = s;
    r.v0 = r.v0 + r.v1;
    r.v1 = rotl(r.v1, ROT_13) ^ r.v0;
    r.v0 = rotl(r.v0, ROT_32);
    r.v2 = r.v2 + r.v3;
    r.v3 = rotl(r.v3, ROT_16) ^ r.v2;
    r.v0 = r.v0 + r.v3;
    r.v3 = rotl(r.v3, ROT_21) ^ r.v0;
    r.v2 = r.v2 + r.v1;
    r.v1 = rotl(r.v1, ROT_17) ^ r.v2;
    r.v2 = rotl(r.v2, ROT_32);
    return r;
  endfunction

  // Absorb one 64-bit block with two rounds
  function automatic sip_state_t compress(sip_state_t s, logic [WORD_W-1:0] m);
    sip_state_t r;
    r    = s;
    r.v3 = r.v3 ^ m;
    r    = sip_round(sip_round(r));
    r.v0 = r.v0 ^ m;
    return r;
  endfunction

endpackage

// ===== hw/rtl/siphash_2_4_keyed_hash.sv =====
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash
// Keyed SipHash-2-4 over byte messages delivered as 64-bit words.
// ----------------------------------------------------------------------------
// Takes one message word per clock cycle, back to back, for as long as the
// result side keeps up. Full words are absorbed into the state register in the
// cycle they are accepted; that two-round compression loop on the state is what
// sets the one-word-per-cycle rate. A last word hands its state and final block
// to a three-stage finalization pipeline (final block compression plus the 0xff
// fold, two rounds, two more rounds plus the output fold), held in turn in
// fin1, fin2, fin3 and then the hash_value register under hash_valid, and the
// next message can start in the cycle after its last word. Stalls on the hash
// side back up through the pipeline; msg_stall rises whenever the first
// finalization stage is full and cannot move on, whatever the word carries.
// The key may be rewritten between messages and applies from the next message
// on. cfg_ready is always high.
module siphash_2_4_keyed_hash (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  siphash_pkg::cfg_reg_t              cfg_index,
  input  logic [siphash_pkg::WORD_W-1:0]     cfg_data,
  // message words
  input  logic                               msg_valid,
  output logic                               msg_stall,
  input  logic [siphash_pkg::WORD_W-1:0]     msg_word,
  input  logic [siphash_pkg::CNT_W-1:0]      valid_bytes,
  input  logic                               last_word,
  // hash results
  output logic                               hash_valid,
  input  logic                               hash_stall,
  output logic [siphash_pkg::WORD_W-1:0]     hash_value
);

  import siphash_pkg::*;

  logic [WORD_W-1:0] key_low;
  logic [WORD_W-1:0] key_high;

  sip_state_t        state;
  logic [LEN_W-1:0]  length_count;
  logic              in_message;

  // finalization pipeline
  logic              fin1_valid;
  sip_state_t        fin1_state;
  logic [WORD_W-1:0] fin1_block;
  logic              fin2_valid;
  sip_state_t        fin2_state;
  logic              fin3_valid;
  sip_state_t        fin3_state;

  logic              msg_accept;
  logic              out_ready;
  logic              fin3_ready;
  logic              fin2_ready;
  logic              fin1_ready;

  logic [CNT_W-1:0]  cnt;
  logic              full_word;
  sip_state_t        cur_state;
  sip_state_t        state_next;
  logic [LEN_W-1:0]  length_next;
  logic [WORD_W-1:0] block_next;
  sip_state_t        fin2_next;
  sip_state_t        fin3_next;
  sip_state_t        fin_out;

  // Configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: each stage moves when the one after it frees up
  assign out_ready  = !hash_valid || !hash_stall;
  assign fin3_ready = !fin3_valid || out_ready;
  assign fin2_ready = !fin2_valid || fin3_ready;
  assign fin1_ready = !fin1_valid || fin2_ready;
  assign msg_stall  = !fin1_ready;
  assign msg_accept = msg_valid && !msg_stall;

  // Absorb: a full word gets two rounds on the running state
  always_comb begin
    cnt         = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
    full_word   = !last_word || (cnt == FULL_BYTES);
    cur_state   = in_message ? state : key_load(key_low, key_high);
    state_next  = full_word ? compress(cur_state, msg_word) : cur_state;
    length_next = (in_message ? length_count : '0)
                + (full_word ? LEN_W'(FULL_BYTES) : LEN_W'(cnt));
    // final block: trailing bytes (if any) plus the length byte on top
    block_next  = '0;
    if (!full_word) begin
      for (int i = 0; i < 8; i++) begin
        if (CNT_W'(i) < cnt) begin
          block_next[8*i +: 8] = msg_word[8*i +: 8];
        end
      end
    end
    block_next[WORD_W-1 -: LEN_W] = length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (msg_accept) begin
      in_message <= !last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_accept) begin
      state        <= state_next;
      length_count <= length_next;
    end
  end

  // Finalization stage math
  always_comb begin
    fin2_next    = compress(fin1_state, fin1_block);
    fin2_next.v2 = fin2_next.v2 ^ FINAL_XOR;
    fin3_next    = sip_round(sip_round(fin2_state));
    fin_out      = sip_round(sip_round(fin3_state));
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      fin1_valid <= 1'b0;
      fin2_valid <= 1'b0;
      fin3_valid <= 1'b0;
      hash_valid <= 1'b0;
    end else begin
      if (fin1_ready) fin1_valid <= msg_accept && last_word;
      if (fin2_ready) fin2_valid <= fin1_valid;
      if (fin3_ready) fin3_valid <= fin2_valid;
      if (out_ready)  hash_valid <= fin3_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (fin1_ready && msg_accept && last_word) begin
      fin1_state <= state_next;
      fin1_block <= block_next;
    end
    if (fin2_ready && fin1_valid) fin2_state <= fin2_next;
    if (fin3_ready && fin2_valid) fin3_state <= fin3_next;
    if (out_ready && fin3_valid) begin
      hash_value <= fin_out.v0 ^ fin_out.v1 ^ fin_out.v2 ^ fin_out.v3;
    end
  end

  // Checks
  a_stall_needs_busy_fin1: assert property (@(posedge clk) disable iff (rst)
    msg_stall |-> fin1_valid)
    else $error("message stalled with finalization entry free");

  a_last_ends_message: assert property (@(posedge clk) disable iff (rst)
    (msg_accept && last_word) |=> (!in_message && fin1_valid))
    else $error("last word did not close the message");

  a_word_opens_message: assert property (@(posedge clk) disable iff (rst)
    (msg_accept && !last_word) |=> in_message)
    else $error("non-last word did not mark message in progress");

  a_fin3_held: assert property (@(posedge clk) disable iff (rst)
    (fin3_valid && hash_valid && hash_stall) |=> (fin3_valid && $stable(fin3_state)))
    else $error("finalization stage lost while result stalled");

endmodule

// ===== test/siphash_2_4_keyed_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash_checker
// Watches the key, message and hash channels of the SipHash-2-4 block. It
// keeps its own copy of the key and hash state, works out the hash of every
// message as its words are accepted, and compares each accepted hash with the
// oldest one it predicted. Reports the mismatch count and the number of hashes
// still awaited.
// ----------------------------------------------------------------------------
module siphash_2_4_keyed_hash_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  siphash_pkg::cfg_reg_t              cfg_index,
  input  logic [siphash_pkg::WORD_W-1:0]     cfg_data,
  input  logic                               msg_valid,
  input  logic                               msg_stall,
  input  logic [siphash_pkg::WORD_W-1:0]     msg_word,
  input  logic [siphash_pkg::CNT_W-1:0]      valid_bytes,
  input  logic                               last_word,
  input  logic                               hash_valid,
  input  logic                               hash_stall,
  input  logic [siphash_pkg::WORD_W-1:0]     hash_value,
  output int                                 errors,
  output int                                 pending
);

  import siphash_pkg::*;

  // Key copy and predicted hash state
  logic [WORD_W-1:0] k_lo, k_hi;
  logic [WORD_W-1:0] v0, v1, v2, v3;
  logic [LEN_W-1:0]  byte_total;
  logic              mid_message;
  int                mismatches;

  // Hashes predicted but not yet seen on the result channel
  logic [WORD_W-1:0] hash_expect_q[$];

  initial begin
    mismatches = 0;
  end

  function automatic logic [WORD_W-1:0] rol64(logic [WORD_W-1:0] x, int n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x};
    return dbl[2*WORD_W-1-n -: WORD_W];
  endfunction

  task automatic sip_mix();
    v0 = v0 + v1;
    v1 = rol64(v1, ROT_13) ^ v0;
    v0 = rol64(v0, ROT_32);
    v2 = v2 + v3;
    v3 = rol64(v3, ROT_16) ^ v2;
    v0 = v0 + v3;
    v3 = rol64(v3, ROT_21) ^ v0;
    v2 = v2 + v1;
    v1 = rol64(v1, ROT_17) ^ v2;
    v2 = rol64(v2, ROT_32);
  endtask

  task automatic sip_absorb(logic [WORD_W-1:0] m);
    v3 = v3 ^ m;
    sip_mix();
    sip_mix();
    v0 = v0 ^ m;
  endtask

  // Fold one accepted word into the running hash; push the hash on a last word
  task automatic sip_predict_word(logic [WORD_W-1:0] w, logic [CNT_W-1:0] nb, logic lst);
    logic [WORD_W-1:0] blk;
    int                n;
    // state reloads from the key only when a message starts
    if (!mid_message) begin
      v0 = SIP_C0 ^ k_lo;
      v1 = SIP_C1 ^ k_hi;
      v2 = SIP_C2 ^ k_lo;
      v3 = SIP_C3 ^ k_hi;
      byte_total = '0;
    end
    mid_message = 1'b1;
    n = (nb > FULL_BYTES) ? 8 : int'(nb);
    if (!lst || n == 8) begin
      // full word, or a short non-last word taken as full
      sip_absorb(w);
      byte_total = byte_total + 8'd8;
      if (!lst) return;
      blk = '0;
    end else begin
      // bytes above the count are dropped
      blk = w & ((64'd1 << (8 * n)) - 64'd1);
      byte_total = byte_total + LEN_W'(n);
    end
    blk[WORD_W-1 -: LEN_W] = byte_total;
    sip_absorb(blk);
    v2 = v2 ^ FINAL_XOR;
    repeat (4) sip_mix();
    hash_expect_q.push_back(v0 ^ v1 ^ v2 ^ v3);
    mid_message = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      k_lo = '0;
      k_hi = '0;
      mid_message = 1'b0;
      byte_total = '0;
      hash_expect_q.delete();
    end else begin
      // key register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_LOW:  k_lo = cfg_data;
          REG_KEY_HIGH: k_hi = cfg_data;
          default: ;
        endcase
      end
      // message word transaction
      if (msg_valid && !msg_stall)
        sip_predict_word(msg_word, valid_bytes, last_word);
      // hash transaction
      if (hash_valid && !hash_stall) begin
        if (hash_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected hash, expected none actual %h", $time, hash_value);
        end else if (hash_expect_q[0] !== hash_value) begin
          mismatches++;
          $display("%0t: hash mismatch, expected %h actual %h",
                   $time, hash_expect_q[0], hash_value);
          void'(hash_expect_q.pop_front());
        end else begin
          void'(hash_expect_q.pop_front());
        end
      end
    end
    errors  <= mismatches;
    pending <= hash_expect_q.size();
  end

endmodule

// ===== test/siphash_2_4_keyed_hash_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash_test
// Stimulus and verdict for the SipHash-2-4 block.
// ----------------------------------------------------------------------------
// Runs a short directed set (empty message, the standard test key, full and
// partial last words, byte counts above eight, short non-last words, junk
// above the byte count), then random messages over several keys, including
// all-zero and all-ones keys, with phases of no idling, sender gaps, result
// stalls and both. Lengths mostly stay short; a few pass 256 bytes so the
// length byte wraps. The checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
module siphash_2_4_keyed_hash_test;
  import siphash_pkg::*;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_reg_t          cfg_index = REG_KEY_LOW;
  logic [WORD_W-1:0] cfg_data = '0;
  logic              msg_valid = 1'b0;
  logic              msg_stall;
  logic [WORD_W-1:0] msg_word = '0;
  logic [CNT_W-1:0]  valid_bytes = '0;
  logic              last_word = 1'b0;
  logic              hash_valid;
  logic              hash_stall = 1'b0;
  logic [WORD_W-1:0] hash_value;

  int chk_errors;
  int chk_pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;

  siphash_2_4_keyed_hash DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg_word    (msg_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .hash_value  (hash_value)
  );

  siphash_2_4_keyed_hash_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg_word    (msg_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .hash_value  (hash_value),
    .errors      (chk_errors),
    .pending     (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result-side backpressure
  initial begin
    forever begin
      @(posedge clk);
      hash_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("** siphash_2_4_keyed_hash: FAILED **");
    $finish;
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Message length in bytes: mostly short, some medium, a few past 256
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 90) return $urandom_range(40);
    if (r < 97) return $urandom_range(120, 41);
    return $urandom_range(330, 250);
  endfunction

  // One word transaction; valid stays high afterward until the next call or a drain
  task automatic send_word(logic [WORD_W-1:0] w, logic [CNT_W-1:0] nb, logic lst);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid   <= 1'b1;
    msg_word    <= w;
    valid_bytes <= nb;
    last_word   <= lst;
    do @(posedge clk); while (msg_stall);
    words_sent++;
  endtask

  // Stop sending and wait for every predicted hash
  task automatic msg_drain();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  task automatic write_key(cfg_reg_t idx, logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Change the key once the block has gone quiet
  task automatic rekey(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    msg_drain();
    repeat (8) @(posedge clk);
    write_key(REG_KEY_LOW, lo);
    write_key(REG_KEY_HIGH, hi);
  endtask

  // Random message; some carry junk byte counts that the block treats as eight
  task automatic send_msg(int nbytes);
    int full, rem;
    bit end8, noisy;
    full  = nbytes / 8;
    rem   = nbytes % 8;
    end8  = (rem == 0 && full > 0) ? 1'($urandom_range(1)) : 1'b0;
    noisy = ($urandom_range(99) < 20);
    for (int i = 0; i < full; i++) begin
      if (end8 && i == full - 1)
        send_word(rand64(), noisy ? CNT_W'($urandom_range(15, 8)) : FULL_BYTES, 1'b1);
      else
        send_word(rand64(), noisy ? CNT_W'($urandom_range(15)) : FULL_BYTES, 1'b0);
    end
    if (!end8) send_word(rand64(), CNT_W'(rem), 1'b1);
  endtask

  initial begin
    int start;
    bit paused;
    logic [WORD_W-1:0] lo, hi;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset key, empty message with junk, one all-ones 8-byte word
    send_word(rand64(), 4'd0, 1'b1);
    send_word({WORD_W{1'b1}}, FULL_BYTES, 1'b1);

    // Standard test key 00..0f
    rekey(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_word(64'h0706050403020100, FULL_BYTES, 1'b1);
    send_word(64'h0706050403020100, FULL_BYTES, 1'b0);
    send_word(64'hff0e0d0c0b0a0908, 4'd7, 1'b1);
    send_word(64'h0, FULL_BYTES, 1'b0);
    send_word({WORD_W{1'b1}}, 4'd0, 1'b1);
    send_word({WORD_W{1'b1}}, 4'd3, 1'b0);
    send_word({WORD_W{1'b1}}, 4'd15, 1'b1);
    send_word(rand64(), 4'd5, 1'b1);

    // All-ones key
    rekey({WORD_W{1'b1}}, {WORD_W{1'b1}});
    send_word({WORD_W{1'b1}}, FULL_BYTES, 1'b0);
    send_word({WORD_W{1'b1}}, 4'd7, 1'b1);
    send_word(64'h0, 4'd0, 1'b1);
    send_word(rand64(), 4'd9, 1'b0);
    send_word(rand64(), 4'd1, 1'b1);

    // Random phases over keys and idling modes
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lo = '0; hi = '0; end
        1: begin lo = {WORD_W{1'b1}}; hi = {WORD_W{1'b1}}; end
        2: begin lo = {WORD_W{1'b1}}; hi = '0; end
        3: begin lo = '0; hi = {WORD_W{1'b1}}; end
        default: begin lo = rand64(); hi = rand64(); end
      endcase
      idle_pct  = 0;
      stall_pct = 0;
      rekey(lo, hi);
      case (p % 4)
        1: idle_pct = 49;
        2: stall_pct = 49;
        3: begin idle_pct = 15; stall_pct = 15; end
        default: ;
      endcase
      start  = words_sent;
      paused = 1'b0;
      while (words_sent - start < 160) begin
        send_msg(pick_len());
        if (!paused && words_sent - start >= 80) begin
          msg_drain();
          paused = 1'b1;
        end else if ($urandom_range(99) < 3) begin
          msg_drain();
        end
      end
    end

    msg_drain();
    repeat (10) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0)
      $display("** siphash_2_4_keyed_hash: PASSED **");
    else
      $display("** siphash_2_4_keyed_hash: FAILED **");
    $finish;
  end

endmodule
